@@ src/brn_pkg.sv @@
// Package for the bounded rational neighbor unit.
// Holds field widths, payload structs and the tree node type; no dependencies.
package brn_pkg;

  localparam int unsigned MAX_DEN    = 60;
  localparam int unsigned FRAC_BITS  = 32;
  localparam int unsigned VAL_W      = 40;
  localparam int unsigned FW         = 6;
  localparam logic [FW-1:0] NEXT_FALLBACK_NUM = FW'(5);
  localparam logic [FW-1:0] PREV_FALLBACK_NUM = FW'(0);
  localparam logic [FW-1:0] FALLBACK_DEN      = FW'(1);
  localparam logic REQ_NEXT = 1'b0;
  localparam logic REQ_PREV = 1'b1;

  typedef struct packed {
    logic                    req_type;
    logic signed [VAL_W-1:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic [FW-1:0] numerator;
    logic [FW-1:0] denominator;
    logic          no_candidate;
  } out_item_t;

  typedef struct packed {
    logic          vld;
    logic [FW-1:0] num;
    logic [FW-1:0] den;
  } node_t;

endpackage

@@ src/brn_lane.sv @@
// Per-denominator candidate: nearest numerator above or below the value.
// Depends on brn_pkg.
module brn_lane #(
  parameter int unsigned Den = 1
) (
  input  logic                                 req_type_i,
  input  logic signed [brn_pkg::VAL_W-1:0]     value_i,
  output brn_pkg::node_t                       cand_o
);

  localparam int unsigned PW = brn_pkg::VAL_W + brn_pkg::FW + 1;
  localparam int unsigned QW = PW - brn_pkg::FRAC_BITS;
  localparam logic [brn_pkg::FW-1:0] DenC  = brn_pkg::FW'(Den);
  localparam logic [QW-1:0]          DenM1 = QW'(Den - 1);

  logic signed [PW-1:0] prod;
  logic [QW-1:0]        fl;
  logic                 frac_nz;
  logic [QW-1:0]        t;

  always_comb begin
    prod    = PW'(value_i) * $signed({1'b0, DenC});
    fl      = prod[PW-1:brn_pkg::FRAC_BITS];
    frac_nz = prod[brn_pkg::FRAC_BITS-1:0] != '0;
    t       = frac_nz ? fl : fl - QW'(1);
    cand_o.den = DenC;
    if (req_type_i == brn_pkg::REQ_NEXT) begin
      if (prod[PW-1]) begin
        cand_o.vld = 1'b1;
        cand_o.num = '0;
      end else begin
        cand_o.vld = fl < DenM1;
        cand_o.num = fl[brn_pkg::FW-1:0] + brn_pkg::FW'(1);
      end
    end else begin
      if (prod[PW-1] || prod == '0) begin
        cand_o.vld = 1'b0;
        cand_o.num = '0;
      end else if (t >= DenM1) begin
        cand_o.vld = DenM1 != '0;
        cand_o.num = DenM1[brn_pkg::FW-1:0];
      end else begin
        cand_o.vld = t != '0;
        cand_o.num = t[brn_pkg::FW-1:0];
      end
    end
  end

endmodule

@@ src/bounded_rational_neighbor_unit.sv @@
// Top level of the bounded rational neighbor unit: lanes, selection tree, output.
// Depends on brn_pkg and brn_lane.
//
// Accepts one item per cycle unless stalled and returns one result per item, in order. The
// stages are an input register, a register of per-denominator candidates, one register
// per level of the selection tree, and the output register.
// All stages advance together; the whole pipe holds while a result waits under stall.
module bounded_rational_neighbor_unit #(
  parameter int unsigned MaxDen = brn_pkg::MAX_DEN
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  brn_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output brn_pkg::out_item_t out_data_o
);

  localparam int unsigned Lvl = $clog2(MaxDen);
  localparam int unsigned N   = 2 ** Lvl;

  logic               adv;
  logic               in_vld_q;
  brn_pkg::in_item_t  in_q;
  logic [Lvl:0]       vld_q;
  logic [Lvl:0]       typ_q;
  brn_pkg::node_t     node_q [Lvl+1][N];
  brn_pkg::node_t     node_d [Lvl+1][N];
  brn_pkg::node_t     leaf   [N];
  logic               out_vld_q;
  brn_pkg::out_item_t out_q, out_d;

  assign adv        = !(out_vld_q && out_stall_i);
  assign in_stall_o = !adv;

  for (genvar g = 0; g < N; g++) begin : g_lane
    if (g >= 1 && g < MaxDen) begin : g_real
      brn_lane #(.Den(g)) u_lane (
        .req_type_i(in_q.req_type),
        .value_i   (in_q.value_in),
        .cand_o    (leaf[g])
      );
    end else begin : g_pad
      assign leaf[g] = '0;
    end
  end

  always_comb begin
    logic [2*brn_pkg::FW-1:0] lx, rx;
    brn_pkg::node_t l, r;
    for (int k = 0; k <= Lvl; k++) begin
      for (int j = 0; j < N; j++) begin
        node_d[k][j] = '0;
      end
    end
    for (int j = 0; j < N; j++) begin
      node_d[0][j] = leaf[j];
    end
    for (int k = 1; k <= Lvl; k++) begin
      for (int j = 0; j < (N >> k); j++) begin
        l  = node_q[k-1][2*j];
        r  = node_q[k-1][2*j+1];
        lx = l.num * r.den;
        rx = r.num * l.den;
        if (r.vld && (!l.vld || (typ_q[k-1] == brn_pkg::REQ_NEXT ? rx < lx : rx > lx))) begin
          node_d[k][j] = r;
        end else begin
          node_d[k][j] = l;
        end
      end
    end
  end

  always_comb begin
    out_d.no_candidate = !node_q[Lvl][0].vld;
    if (node_q[Lvl][0].vld) begin
      out_d.numerator   = node_q[Lvl][0].num;
      out_d.denominator = node_q[Lvl][0].den;
    end else begin
      out_d.numerator   = (typ_q[Lvl] == brn_pkg::REQ_NEXT) ?
                          brn_pkg::NEXT_FALLBACK_NUM : brn_pkg::PREV_FALLBACK_NUM;
      out_d.denominator = brn_pkg::FALLBACK_DEN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      in_vld_q  <= in_valid_i;
      vld_q     <= {vld_q[Lvl-1:0], in_vld_q};
      out_vld_q <= vld_q[Lvl];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q  <= in_data_i;
      typ_q <= {typ_q[Lvl-1:0], in_q.req_type};
      out_q <= out_d;
      node_q <= node_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_found_proper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_q.no_candidate |-> out_q.numerator < out_q.denominator)
    else $error("found fraction not below one");

  a_fallback_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.no_candidate |-> out_q.denominator == brn_pkg::FALLBACK_DEN)
    else $error("fallback denominator wrong");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_stall_i |=> out_vld_q && $stable(vld_q))
    else $error("pipe moved under stall");

endmodule

@@ verif/tb_top.sv @@
// Testbench for bounded_rational_neighbor_unit: random and directed values in both directions.
// Depends on brn_pkg; keeps its own neighbor search and checks results in order.
module tb_top;

  class neighbor_checker;
    brn_pkg::out_item_t pending_neighbors[$];
    int                 errors;

    function brn_pkg::out_item_t search_neighbor(brn_pkg::in_item_t it);
      brn_pkg::out_item_t res;
      longint             v;
      longint             best_n;
      longint             best_d;
      bit                 below;
      bit                 found;
      bit                 take;
      v      = longint'($signed(it.value_in));
      below  = (it.req_type == brn_pkg::REQ_PREV);
      best_n = below ? longint'(brn_pkg::PREV_FALLBACK_NUM)
                     : longint'(brn_pkg::NEXT_FALLBACK_NUM);
      best_d = longint'(brn_pkg::FALLBACK_DEN);
      found  = 0;
      for (longint b = 1; b < brn_pkg::MAX_DEN; b++) begin
        for (longint a = 0; a < b; a++) begin
          if (below) begin
            take = ((a <<< brn_pkg::FRAC_BITS) < v * b) && (a * best_d > best_n * b);
          end else begin
            take = ((a <<< brn_pkg::FRAC_BITS) > v * b) && (a * best_d < best_n * b);
          end
          if (take) begin
            best_n = a;
            best_d = b;
            found  = 1;
          end
        end
      end
      res.numerator    = best_n[brn_pkg::FW-1:0];
      res.denominator  = best_d[brn_pkg::FW-1:0];
      res.no_candidate = !found;
      return res;
    endfunction

    function void note_input(brn_pkg::in_item_t it);
      pending_neighbors.push_back(search_neighbor(it));
    endfunction

    function void check_result(brn_pkg::out_item_t got);
      brn_pkg::out_item_t want;
      if (pending_neighbors.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
        return;
      end
      want = pending_neighbors.pop_front();
      if (got.numerator !== want.numerator) begin
        $display("%0t: numerator expected %0d actual %0d", $realtime,
                 want.numerator, got.numerator);
        errors++;
      end
      if (got.denominator !== want.denominator) begin
        $display("%0t: denominator expected %0d actual %0d", $realtime,
                 want.denominator, got.denominator);
        errors++;
      end
      if (got.no_candidate !== want.no_candidate) begin
        $display("%0t: no_candidate expected %0d actual %0d", $realtime,
                 want.no_candidate, got.no_candidate);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  brn_pkg::in_item_t  in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  brn_pkg::out_item_t out_data_o;

  neighbor_checker checker_h;
  bit              calm_phase;

  bounded_rational_neighbor_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic send_value(logic req, logic signed [brn_pkg::VAL_W-1:0] val);
    brn_pkg::in_item_t it;
    int                gap;
    it.req_type = req;
    it.value_in = val;
    gap = calm_phase ? 0 : $urandom_range(0, 18);
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    checker_h.note_input(it);
  endtask

  function automatic logic signed [brn_pkg::VAL_W-1:0] near_fraction(int a, int b, int off);
    longint q;
    q = (longint'(a) <<< brn_pkg::FRAC_BITS) / b + off;
    return q[brn_pkg::VAL_W-1:0];
  endfunction

  initial begin
    int b;
    int a;
    int sel;
    logic signed [brn_pkg::VAL_W-1:0] val;
    checker_h   = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    calm_phase  = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int r = 0; r < 2; r++) begin
      send_value(r[0], {1'b0, {(brn_pkg::VAL_W-1){1'b1}}});
      send_value(r[0], {1'b1, {(brn_pkg::VAL_W-1){1'b0}}});
      send_value(r[0], '0);
      send_value(r[0], 40'sd1);
      send_value(r[0], -40'sd1);
      send_value(r[0], near_fraction(1, 2, 0));
      send_value(r[0], near_fraction(58, 59, 0));
      send_value(r[0], near_fraction(58, 59, -1));
      send_value(r[0], near_fraction(1, 59, 0));
      send_value(r[0], near_fraction(1, 1, 0));
      send_value(r[0], near_fraction(1, 1, -1));
      send_value(r[0], near_fraction(2, 4, 1));
    end
    for (int i = 0; i < 1200; i++) begin
      if (i % 150 == 0) calm_phase = ($urandom_range(0, 2) == 0);
      sel = $urandom_range(0, 9);
      b   = $urandom_range(1, 63);
      a   = $urandom_range(0, b);
      if (sel < 2) begin
        val = {8'($urandom_range(0, 255)), $urandom()};
      end else if (sel < 5) begin
        val = {8'h00, $urandom()};
      end else if (sel < 6) begin
        val = near_fraction(58, 59, int'($urandom_range(0, 6)) - 3);
      end else begin
        val = near_fraction(a, b, int'($urandom_range(0, 6)) - 3);
      end
      send_value(1'($urandom_range(0, 1)), val);
    end
    in_valid_i <= 1'b0;
    while (checker_h.pending_neighbors.size() != 0) @(posedge clk_i);
    repeat (3 * ($clog2(brn_pkg::MAX_DEN) + 3)) @(posedge clk_i);
    if (checker_h.errors == 0) begin
      $display("PASS bounded_rational_neighbor_unit");
    end else begin
      $display("FAIL bounded_rational_neighbor_unit");
    end
    $finish;
  end

  initial begin
    int hold;
    @(posedge rst_ni);
    forever begin
      hold = calm_phase ? 0 : $urandom_range(0, 18);
      repeat (hold) begin
        out_stall_i <= 1'b1;
        @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      checker_h.check_result(out_data_o);
    end
  end

  initial begin
    #8000000;
    $display("FAIL bounded_rational_neighbor_unit");
    $finish;
  end

endmodule

@@ bounded_rational_neighbor_unit.f @@
src/brn_pkg.sv
src/brn_lane.sv
src/bounded_rational_neighbor_unit.sv
verif/tb_top.sv
